@@ design/tctc_pkg.sv @@
// Shared types, codes and fixed-point helpers of the timed cover tilt controller.
// Used by every module of the block but tctc_muldiv; depends on nothing else.
`default_nettype none

package tctc_pkg;

  localparam logic [16:0] FULL_Q = 17'd65536;
  localparam logic [16:0] HALF_Q = 17'd32768;

  // Operations (direction of travel).
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // Modes of the cover state machine.
  localparam logic [1:0] M_IDLE     = 2'd0;
  localparam logic [1:0] M_MOVING   = 2'd1;
  localparam logic [1:0] M_STOPPING = 2'd2;
  localparam logic [1:0] M_CALIB    = 2'd3;

  // Input commands.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;
  localparam logic [1:0] CMD_TOGGLE = 2'd3;

  // Motor events.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_OPEN  = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [1:0] EV_STOP  = 2'd3;

  // Travel stages of a moving tick.
  localparam logic [1:0] STG_INR = 2'd0;
  localparam logic [1:0] STG_TLT = 2'd1;
  localparam logic [1:0] STG_POS = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_OPEN_MS     = 3'd0;
  localparam logic [2:0] REG_CLOSE_MS    = 3'd1;
  localparam logic [2:0] REG_TILT_OPEN   = 3'd2;
  localparam logic [2:0] REG_TILT_CLOSE  = 3'd3;
  localparam logic [2:0] REG_ILK_WAIT    = 3'd4;
  localparam logic [2:0] REG_RECAL_CLOSE = 3'd5;
  localparam logic [2:0] REG_RECAL_OPEN  = 3'd6;
  localparam logic [2:0] REG_LINK_MODE   = 3'd7;

  // Default motor timing constants.
  localparam int unsigned DEF_INERTIA_OPEN_MS    = 0;
  localparam int unsigned DEF_INERTIA_CLOSE_MS   = 0;
  localparam int unsigned DEF_ACTIVATION_OPEN_MS  = 0;
  localparam int unsigned DEF_ACTIVATION_CLOSE_MS = 0;

  typedef struct packed {
    logic [21:0] open_ms;
    logic [21:0] close_ms;
    logic [21:0] tilt_open_ms;
    logic [21:0] tilt_close_ms;
    logic [21:0] ilk_wait_ms;
    logic [21:0] recal_close_ms;
    logic [21:0] recal_open_ms;
    logic [1:0]  link_mode;
  } cfg_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       item;
    logic [1:0] stage;
    logic       div_go;
    logic       apply;
    logic       mul_go;
    logic       trav;
    logic       out_load;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic go_move;
    logic stage_on;
    logic stage_end;
    logic md_done;
  } sts_t;

  // Rounds a Q16 value to the nearest 1/100 of full scale.
  function automatic logic [16:0] round_hundredth(input logic [16:0] v);
    logic [23:0] t;
    logic [6:0]  k;
    logic [20:0] x;
    logic [42:0] m;
    t = 24'(v) * 24'd100 + 24'd32768;
    k = t[22:16];
    x = {k, 14'b0} + 21'd12;
    // x / 25 through a reciprocal that is exact for x below 2**21.
    m = 43'(x) * 43'd2684355;
    return m[42:26];
  endfunction

  function automatic logic [1:0] dir_of(input logic [16:0] goal, input logic [16:0] cur);
    logic [1:0] d;
    if (goal == cur) d = OP_IDLE;
    else if (goal < cur) d = OP_CLOSE;
    else d = OP_OPEN;
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/tctc_muldiv.sv @@
// Shared iterative unit: 48 by 22 bit restoring divider and 49 by 22 bit shift-add multiplier.
// Standalone; used by the datapath of the timed cover tilt controller.
`default_nettype none

module tctc_muldiv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        div_go,
  input  wire logic        mul_go,
  input  wire logic [47:0] dividend,
  input  wire logic [21:0] divisor,
  input  wire logic [48:0] mcand,
  input  wire logic [21:0] mplier,
  output logic             done,
  output logic [47:0]      quo,
  output logic [31:0]      prod_mid
);

  logic        busy;
  logic        is_mul;
  logic [5:0]  cnt;
  logic [21:0] rem;
  logic [21:0] dvs;
  logic [48:0] mc;
  logic [70:0] prod;
  logic [22:0] rem_sh;
  logic [22:0] diff;
  logic [49:0] psum;

  assign rem_sh   = {rem, quo[47]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign psum     = {1'b0, prod[70:22]} + (prod[0] ? {1'b0, mc} : 50'd0);
  assign prod_mid = prod[47:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (div_go) begin
        busy   <= 1'b1;
        is_mul <= 1'b0;
        cnt    <= 6'd47;
      end else if (mul_go) begin
        busy   <= 1'b1;
        is_mul <= 1'b1;
        cnt    <= 6'd21;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (mul_go) begin
      mc   <= mcand;
      prod <= {49'b0, mplier};
    end else if (busy) begin
      if (is_mul) begin
        prod <= {psum, prod[21:1]};
      end else if (!diff[22]) begin
        rem <= diff[21:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= rem_sh[21:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ design/tctc_datapath.sv @@
// Datapath of the timed cover tilt controller: cover state, travel arithmetic, result word.
// Depends on tctc_pkg and tctc_muldiv; driven by tctc_ctrl.
`default_nettype none

module tctc_datapath #(
  parameter int unsigned INERTIA_OPEN_MS     = tctc_pkg::DEF_INERTIA_OPEN_MS,
  parameter int unsigned INERTIA_CLOSE_MS    = tctc_pkg::DEF_INERTIA_CLOSE_MS,
  parameter int unsigned ACTIVATION_OPEN_MS  = tctc_pkg::DEF_ACTIVATION_OPEN_MS,
  parameter int unsigned ACTIVATION_CLOSE_MS = tctc_pkg::DEF_ACTIVATION_CLOSE_MS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tctc_pkg::ctl_t      ctl,
  output tctc_pkg::sts_t           sts,
  input  wire tctc_pkg::cfg_t      cfg,
  input  wire logic [1:0]          command,
  input  wire logic [15:0]         elapsed_ms,
  input  wire logic                has_position,
  input  wire logic [16:0]         target_position,
  input  wire logic                has_tilt,
  input  wire logic [16:0]         target_tilt,
  output logic [1:0]               motor_event,
  output logic [1:0]               operation,
  output logic [16:0]              position_report,
  output logic [16:0]              tilt_report,
  output logic                     publish
);

  localparam logic [15:0] IN_OPEN  = 16'(INERTIA_OPEN_MS);
  localparam logic [15:0] IN_CLOSE = 16'(INERTIA_CLOSE_MS);
  localparam logic [21:0] AC_OPEN  = 22'(ACTIVATION_OPEN_MS);
  localparam logic [21:0] AC_CLOSE = 22'(ACTIVATION_CLOSE_MS);

  // Latched item.
  logic [1:0]  i_cmd;
  logic        i_hp, i_ht;
  logic [16:0] i_tp, i_tg;

  // Cover state.
  logic [1:0]  mode, cur_op, prev_op, ilk_dir, ev;
  logic        pub;
  logic [16:0] est_pos, est_tilt, gpos, gtilt;
  logic        gpok, gtok;
  logic [31:0] time_now, last_rec, last_pub, ilk_stamp, travel;
  logic [21:0] act_left, recal;
  logic signed [17:0] lvl;
  logic [48:0] rest_abs;

  logic [1:0]  mode_next, cur_op_next, prev_op_next, ilk_dir_next, ev_next;
  logic        pub_next;
  logic [16:0] est_pos_next, est_tilt_next, gpos_next, gtilt_next;
  logic        gpok_next, gtok_next;
  logic [31:0] time_now_next, last_rec_next, last_pub_next, ilk_stamp_next, travel_next;
  logic [21:0] act_left_next, recal_next;
  logic signed [17:0] lvl_next;
  logic [48:0] rest_abs_next;

  // Derived configuration.
  logic        tilt_en, closing;
  logic [21:0] toe, tce, tt, md;
  logic [15:0] it;
  logic [9:0]  thr;
  logic [28:0] thr_m;
  logic        inr_on, tlt_on, pos_on;

  // Arithmetic unit.
  logic [47:0] md_quo;
  logic [31:0] md_prod;
  logic        md_done;
  logic [21:0] div_dvs;

  assign tilt_en = (cfg.tilt_open_ms != 22'd0) && (cfg.tilt_close_ms != 22'd0);
  assign toe     = tilt_en ? cfg.tilt_open_ms : 22'd0;
  assign tce     = tilt_en ? cfg.tilt_close_ms : 22'd0;
  assign closing = (cur_op == tctc_pkg::OP_CLOSE);
  assign tt      = closing ? tce : toe;
  assign it      = closing ? IN_CLOSE : IN_OPEN;
  assign md      = ((closing ? cfg.close_ms : cfg.open_ms) == 22'd0) ? 22'd1
                 : (closing ? cfg.close_ms : cfg.open_ms);
  // Publish interval while tilting: a fifth of the tilt time, at most one second.
  assign thr_m   = 29'(tt[12:0]) * 29'd52429;
  assign thr     = (tt >= 22'd5005) ? 10'd1000 : thr_m[27:18];

  assign inr_on = (it != 16'd0) && (closing ? (lvl > -18'sd32768) : (lvl < 18'sd32768));
  assign tlt_on = (tt != 22'd0) && (closing ? (est_tilt != 17'd0) : (est_tilt != tctc_pkg::FULL_Q));
  assign pos_on = closing ? (est_pos != 17'd0) : (est_pos != tctc_pkg::FULL_Q);

  always_comb begin
    case (ctl.stage)
      tctc_pkg::STG_INR: div_dvs = 22'(it);
      tctc_pkg::STG_TLT: div_dvs = tt;
      default:           div_dvs = md;
    endcase
  end

  tctc_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .div_go   (ctl.div_go),
    .mul_go   (ctl.mul_go),
    .dividend ({travel, 16'b0}),
    .divisor  (div_dvs),
    .mcand    (rest_abs),
    .mplier   ((ctl.stage == tctc_pkg::STG_INR) ? 22'(it) : tt),
    .done     (md_done),
    .quo      (md_quo),
    .prod_mid (md_prod)
  );

  function automatic logic at_goal(input logic [1:0] op, input logic ok,
                                   input logic [16:0] goal, input logic [16:0] cur);
    logic r;
    if (op == tctc_pkg::OP_OPEN) r = !ok || (cur >= goal);
    else if (op == tctc_pkg::OP_CLOSE) r = ok && (cur <= goal);
    else r = 1'b1;
    return r;
  endfunction

  function automatic logic at_extreme(input logic [16:0] p, input logic [16:0] t,
                                      input logic [21:0] o_eff, input logic [21:0] c_eff);
    return ((p == 17'd0) && ((c_eff == 22'd0) || (t == 17'd0))) ||
           ((p == tctc_pkg::FULL_Q) && ((o_eff == 22'd0) || (t == tctc_pkg::FULL_Q)));
  endfunction

  always_comb begin
    logic [1:0]  c, d;
    logic        start;
    logic [31:0] now, trav, lp;
    logic signed [49:0] step, lv, cl, rest;
    logic [16:0] v;

    mode_next      = mode;
    cur_op_next    = cur_op;
    prev_op_next   = prev_op;
    ilk_dir_next   = ilk_dir;
    ev_next        = ev;
    pub_next       = pub;
    est_pos_next   = est_pos;
    est_tilt_next  = est_tilt;
    gpos_next      = gpos;
    gtilt_next     = gtilt;
    gpok_next      = gpok;
    gtok_next      = gtok;
    time_now_next  = time_now;
    last_rec_next  = last_rec;
    last_pub_next  = last_pub;
    ilk_stamp_next = ilk_stamp;
    travel_next    = travel;
    act_left_next  = act_left;
    recal_next     = recal;
    lvl_next       = lvl;
    rest_abs_next  = rest_abs;
    sts            = '0;
    c     = cur_op;
    d     = tctc_pkg::OP_IDLE;
    start = 1'b0;
    now   = time_now;
    trav  = 32'd0;
    lp    = last_pub;
    step  = $signed({2'b0, md_quo});
    lv    = '0;
    cl    = '0;
    rest  = '0;
    v     = '0;

    case (ctl.stage)
      tctc_pkg::STG_INR: sts.stage_on = inr_on;
      tctc_pkg::STG_TLT: sts.stage_on = tlt_on;
      default:           sts.stage_on = pos_on;
    endcase
    sts.md_done = md_done;

    if (ctl.load) begin
      ev_next  = tctc_pkg::EV_NONE;
      pub_next = 1'b0;
      if (command == tctc_pkg::CMD_TICK) time_now_next = time_now + 32'(elapsed_ms);
    end else if (ctl.item) begin
      case (i_cmd)
        tctc_pkg::CMD_STOP: begin
          gpok_next = 1'b0;
          gtok_next = 1'b0;
          mode_next = tctc_pkg::M_STOPPING;
        end
        tctc_pkg::CMD_SET: begin
          if (i_hp || i_ht) begin
            gtok_next  = i_ht;
            gtilt_next = i_tg;
            gpok_next  = i_hp;
            if (i_hp) begin
              gpos_next = i_tp;
              if ((i_tp == 17'd0) && cfg.link_mode[0] && !i_ht) begin
                gtilt_next = 17'd0;
                gtok_next  = 1'b1;
              end else if ((i_tp == tctc_pkg::FULL_Q) && cfg.link_mode[1] && !i_ht) begin
                gtilt_next = tctc_pkg::FULL_Q;
                gtok_next  = 1'b1;
              end
            end
            if (mode == tctc_pkg::M_MOVING) begin
              if (gpok_next && (gpos_next != est_pos)) d = tctc_pkg::dir_of(gpos_next, est_pos);
              else if (gtok_next && (gtilt_next != est_tilt))
                d = tctc_pkg::dir_of(gtilt_next, est_tilt);
              if (d != cur_op) mode_next = tctc_pkg::M_STOPPING;
            end
            if (mode_next == tctc_pkg::M_CALIB) begin
              if (gpok_next && (((est_pos == 17'd0) && (gpos_next != 17'd0)) ||
                  ((est_pos == tctc_pkg::FULL_Q) && (gpos_next != tctc_pkg::FULL_Q))))
                mode_next = tctc_pkg::M_STOPPING;
              if (gtok_next && (((est_tilt == 17'd0) && (gtilt_next != 17'd0)) ||
                  ((est_tilt == tctc_pkg::FULL_Q) && (gtilt_next != tctc_pkg::FULL_Q))))
                mode_next = tctc_pkg::M_STOPPING;
            end
          end
        end
        tctc_pkg::CMD_TOGGLE: begin
          if (cur_op != tctc_pkg::OP_IDLE) begin
            mode_next = tctc_pkg::M_STOPPING;
            gpok_next = 1'b0;
            gtok_next = 1'b0;
          end else if ((est_pos == 17'd0) && (est_tilt == 17'd0)) begin
            gpos_next = tctc_pkg::FULL_Q;
            gpok_next = 1'b1;
          end else if ((est_pos == tctc_pkg::FULL_Q) && (est_tilt == tctc_pkg::FULL_Q)) begin
            gpos_next = 17'd0;
            gpok_next = 1'b1;
          end else if (prev_op == tctc_pkg::OP_CLOSE) begin
            if (est_pos != tctc_pkg::FULL_Q) begin
              gpos_next = tctc_pkg::FULL_Q;
              gpok_next = 1'b1;
            end else begin
              gtilt_next = tctc_pkg::FULL_Q;
              gtok_next  = 1'b1;
            end
          end else begin
            if (est_pos != 17'd0) begin
              gpos_next = 17'd0;
              gpok_next = 1'b1;
            end else begin
              gtilt_next = 17'd0;
              gtok_next  = 1'b1;
            end
          end
        end
        default: begin
          if (!((mode == tctc_pkg::M_IDLE) && !gpok && !gtok)) begin
            case (mode)
              tctc_pkg::M_CALIB: begin
                if ((now - last_rec) >= 32'(recal)) begin
                  mode_next = tctc_pkg::M_STOPPING;
                  gpok_next = 1'b0;
                  gtok_next = 1'b0;
                end
              end
              tctc_pkg::M_STOPPING: begin
                ev_next = tctc_pkg::EV_STOP;
                if (cur_op != tctc_pkg::OP_IDLE) begin
                  ilk_stamp_next = now;
                  ilk_dir_next   = closing ? tctc_pkg::OP_OPEN : tctc_pkg::OP_CLOSE;
                end else begin
                  ilk_dir_next = tctc_pkg::OP_IDLE;
                end
                mode_next     = tctc_pkg::M_IDLE;
                prev_op_next  = cur_op;
                cur_op_next   = tctc_pkg::OP_IDLE;
                est_pos_next  = tctc_pkg::round_hundredth(est_pos);
                est_tilt_next = tctc_pkg::round_hundredth(est_tilt);
                pub_next      = 1'b1;
              end
              tctc_pkg::M_IDLE: begin
                if (gpok) begin
                  c = tctc_pkg::dir_of(gpos, est_pos);
                  if (c == tctc_pkg::OP_IDLE) begin
                    gpok_next = 1'b0;
                    if (gtok) c = tctc_pkg::dir_of(gtilt, est_tilt);
                  end
                end else begin
                  c = tctc_pkg::dir_of(gtilt, est_tilt);
                end
                start = 1'b1;
                if (c == tctc_pkg::OP_IDLE) begin
                  if (at_extreme(est_pos, est_tilt, toe, tce)) begin
                    c         = (est_pos == 17'd0) ? tctc_pkg::OP_CLOSE : tctc_pkg::OP_OPEN;
                    gpos_next = (est_pos == 17'd0) ? 17'd0 : tctc_pkg::FULL_Q;
                    gpok_next = 1'b1;
                  end else begin
                    gpok_next = 1'b0;
                    gtok_next = 1'b0;
                    start     = 1'b0;
                  end
                end
                cur_op_next = c;
                // A reversal waits out the interlock time after the last stop.
                if (start && (c == ilk_dir) && ((now - ilk_stamp) < 32'(cfg.ilk_wait_ms)))
                  start = 1'b0;
                if (start) begin
                  if (c == tctc_pkg::OP_CLOSE) begin
                    ev_next       = tctc_pkg::EV_CLOSE;
                    recal_next    = cfg.recal_close_ms;
                    act_left_next = AC_CLOSE;
                  end else begin
                    ev_next       = tctc_pkg::EV_OPEN;
                    recal_next    = cfg.recal_open_ms;
                    act_left_next = AC_OPEN;
                  end
                  last_rec_next = now;
                  mode_next     = tctc_pkg::M_MOVING;
                end
              end
              default: begin
                trav          = now - last_rec;
                last_rec_next = now;
                if ((act_left != 22'd0) && (trav <= 32'(act_left))) begin
                  act_left_next = act_left - trav[21:0];
                end else begin
                  if (act_left != 22'd0) begin
                    trav          = trav - 32'(act_left);
                    act_left_next = 22'd0;
                  end
                  travel_next = trav;
                  sts.go_move = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end else if (ctl.apply) begin
      case (ctl.stage)
        tctc_pkg::STG_INR: begin
          lv = closing ? (50'(lvl) - step) : (50'(lvl) + step);
          if (lv < -50'sd32768) cl = -50'sd32768;
          else if (lv > 50'sd32768) cl = 50'sd32768;
          else cl = lv;
          rest          = lv - cl;
          lvl_next      = cl[17:0];
          rest_abs_next = rest[49] ? 49'(-rest) : rest[48:0];
          sts.stage_end = (rest == 50'sd0);
        end
        tctc_pkg::STG_TLT: begin
          lv = closing ? ($signed({33'b0, est_tilt}) - step) : ($signed({33'b0, est_tilt}) + step);
          if (lv < 50'sd0) cl = 50'sd0;
          else if (lv > 50'sd65536) cl = 50'sd65536;
          else cl = lv;
          rest          = lv - cl;
          rest_abs_next = rest[49] ? 49'(-rest) : rest[48:0];
          v             = cl[16:0];
          est_tilt_next = v;
          if (!gpok && at_goal(cur_op, gtok, gtilt, v)) begin
            gtok_next     = 1'b0;
            last_pub_next = now;
            est_tilt_next = tctc_pkg::round_hundredth(v);
            if ((recal != 22'd0) && at_extreme(est_pos, est_tilt_next, toe, tce)) begin
              mode_next = tctc_pkg::M_CALIB;
              pub_next  = 1'b1;
            end else begin
              mode_next = tctc_pkg::M_STOPPING;
            end
            sts.stage_end = 1'b1;
          end else begin
            if ((now - last_pub) > 32'(thr)) begin
              pub_next      = 1'b1;
              last_pub_next = now;
            end
            sts.stage_end = (rest == 50'sd0);
          end
        end
        default: begin
          v = est_pos;
          if (pos_on) begin
            lv = closing ? ($signed({33'b0, est_pos}) - step) : ($signed({33'b0, est_pos}) + step);
            if (lv < 50'sd0) cl = 50'sd0;
            else if (lv > 50'sd65536) cl = 50'sd65536;
            else cl = lv;
            v = cl[16:0];
          end
          est_pos_next = v;
          if (at_goal(cur_op, gpok, gpos, v)) begin
            gpok_next    = 1'b0;
            lp           = now;
            est_pos_next = tctc_pkg::round_hundredth(v);
            if ((recal != 22'd0) && at_extreme(est_pos_next, est_tilt, toe, tce)) begin
              mode_next = tctc_pkg::M_CALIB;
              pub_next  = 1'b1;
            end else begin
              mode_next = tctc_pkg::M_STOPPING;
            end
          end
          last_pub_next = lp;
          if ((now - lp) > 32'd1000) begin
            pub_next      = 1'b1;
            last_pub_next = now;
          end
          sts.stage_end = 1'b1;
        end
      endcase
    end else if (ctl.trav) begin
      travel_next = md_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      i_cmd <= command;
      i_hp  <= has_position;
      i_ht  <= has_tilt;
      i_tp  <= (target_position > tctc_pkg::FULL_Q) ? tctc_pkg::FULL_Q : target_position;
      i_tg  <= (target_tilt > tctc_pkg::FULL_Q) ? tctc_pkg::FULL_Q : target_tilt;
    end
    rest_abs <= rest_abs_next;
    travel   <= travel_next;
    if (ctl.out_load) begin
      motor_event     <= ev;
      operation       <= cur_op;
      position_report <= est_pos;
      tilt_report     <= est_tilt;
      publish         <= pub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= tctc_pkg::M_IDLE;
      cur_op    <= tctc_pkg::OP_IDLE;
      prev_op   <= tctc_pkg::OP_IDLE;
      ilk_dir   <= tctc_pkg::OP_IDLE;
      ev        <= tctc_pkg::EV_NONE;
      pub       <= 1'b0;
      est_pos   <= tctc_pkg::HALF_Q;
      est_tilt  <= tctc_pkg::HALF_Q;
      gpos      <= 17'd0;
      gtilt     <= 17'd0;
      gpok      <= 1'b0;
      gtok      <= 1'b0;
      time_now  <= 32'd0;
      last_rec  <= 32'd0;
      last_pub  <= 32'd0;
      ilk_stamp <= 32'd0;
      act_left  <= 22'd0;
      recal     <= 22'd0;
      lvl       <= 18'sd0;
    end else begin
      mode      <= mode_next;
      cur_op    <= cur_op_next;
      prev_op   <= prev_op_next;
      ilk_dir   <= ilk_dir_next;
      ev        <= ev_next;
      pub       <= pub_next;
      est_pos   <= est_pos_next;
      est_tilt  <= est_tilt_next;
      gpos      <= gpos_next;
      gtilt     <= gtilt_next;
      gpok      <= gpok_next;
      gtok      <= gtok_next;
      time_now  <= time_now_next;
      last_rec  <= last_rec_next;
      last_pub  <= last_pub_next;
      ilk_stamp <= ilk_stamp_next;
      act_left  <= act_left_next;
      recal     <= recal_next;
      lvl       <= lvl_next;
    end
  end

endmodule

`default_nettype wire

@@ design/tctc_ctrl.sv @@
// Sequencer of the timed cover tilt controller: steps moving ticks through travel stages.
// Depends on tctc_pkg; drives tctc_datapath through command and status structs.
`default_nettype none

module tctc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tctc_pkg::ctl_t      ctl,
  input  wire tctc_pkg::sts_t sts
);

  localparam logic [2:0] S_WAIT  = 3'd0;
  localparam logic [2:0] S_ITEM  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_MULGO = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] stage, stage_next;
  logic       out_valid_next;

  assign in_stall = (state != S_WAIT);

  always_comb begin
    state_next     = state;
    stage_next     = stage;
    out_valid_next = out_valid && out_stall;
    ctl            = '0;
    ctl.stage      = stage;
    case (state)
      S_WAIT: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_ITEM;
        end
      end
      S_ITEM: begin
        ctl.item   = 1'b1;
        stage_next = tctc_pkg::STG_INR;
        state_next = sts.go_move ? S_CHK : S_DONE;
      end
      S_CHK: begin
        if (sts.stage_on) begin
          ctl.div_go = 1'b1;
          state_next = S_DIV;
        end else if (stage == tctc_pkg::STG_POS) begin
          state_next = S_APPLY;
        end else begin
          stage_next = stage + 2'd1;
        end
      end
      S_DIV: begin
        if (sts.md_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = sts.stage_end ? S_DONE : S_MULGO;
      end
      S_MULGO: begin
        ctl.mul_go = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.md_done) begin
          ctl.trav   = 1'b1;
          stage_next = stage + 2'd1;
          state_next = S_CHK;
        end
      end
      default: begin
        if (!out_valid || !out_stall) begin
          ctl.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      stage     <= tctc_pkg::STG_INR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stage     <= stage_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ design/timed_cover_tilt_controller.sv @@
// Timed cover tilt controller: estimates blind position and slat tilt from elapsed time.
// Top level; depends on tctc_pkg, tctc_ctrl, tctc_datapath and tctc_muldiv.
`default_nettype none

// Each input word is one command (tick, stop, set targets, toggle) and yields exactly one
// result word with the motor event, the current operation, the Q16 position and tilt
// estimates and a publish flag. Words are taken one at a time: a stop, set-targets or
// toggle word, or a tick that does not advance a moving cover, is latched, applied to
// the cover state and then loaded into the output register. A tick that advances a
// moving cover runs up to three travel stages (inertia ramp, tilt, position) on one
// shared iterative divider and multiplier: each stage that is active runs a 48-bit
// division, and a stage that hands leftover time to the next adds a multiplication.
// The input is stalled until the result is in the output register; a new word may be
// accepted while that result waits to be taken. Configuration is an APB-style register
// port with pready always high; it must only be written while the block is idle.

module timed_cover_tilt_controller #(
  parameter int unsigned INERTIA_OPEN_MS     = tctc_pkg::DEF_INERTIA_OPEN_MS,
  parameter int unsigned INERTIA_CLOSE_MS    = tctc_pkg::DEF_INERTIA_CLOSE_MS,
  parameter int unsigned ACTIVATION_OPEN_MS  = tctc_pkg::DEF_ACTIVATION_OPEN_MS,
  parameter int unsigned ACTIVATION_CLOSE_MS = tctc_pkg::DEF_ACTIVATION_CLOSE_MS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] elapsed_ms,
  input  wire logic        has_position,
  input  wire logic [16:0] target_position,
  input  wire logic        has_tilt,
  input  wire logic [16:0] target_tilt,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       motor_event,
  output logic [1:0]       operation,
  output logic [16:0]      position_report,
  output logic [16:0]      tilt_report,
  output logic             publish,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tctc_pkg::cfg_t cfg;
  tctc_pkg::ctl_t ctl;
  tctc_pkg::sts_t sts;
  logic           cfg_wr;

  // Register file. Every register is 22 bits or less, so each sits at 4 * index.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_ms        <= 22'd10000;
      cfg.close_ms       <= 22'd10000;
      cfg.tilt_open_ms   <= 22'd0;
      cfg.tilt_close_ms  <= 22'd0;
      cfg.ilk_wait_ms    <= 22'd0;
      cfg.recal_close_ms <= 22'd0;
      cfg.recal_open_ms  <= 22'd0;
      cfg.link_mode      <= 2'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        tctc_pkg::REG_OPEN_MS:     cfg.open_ms        <= pwdata[21:0];
        tctc_pkg::REG_CLOSE_MS:    cfg.close_ms       <= pwdata[21:0];
        tctc_pkg::REG_TILT_OPEN:   cfg.tilt_open_ms   <= pwdata[21:0];
        tctc_pkg::REG_TILT_CLOSE:  cfg.tilt_close_ms  <= pwdata[21:0];
        tctc_pkg::REG_ILK_WAIT:    cfg.ilk_wait_ms    <= pwdata[21:0];
        tctc_pkg::REG_RECAL_CLOSE: cfg.recal_close_ms <= pwdata[21:0];
        tctc_pkg::REG_RECAL_OPEN:  cfg.recal_open_ms  <= pwdata[21:0];
        default:                   cfg.link_mode      <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tctc_pkg::REG_OPEN_MS:     prdata = 32'(cfg.open_ms);
      tctc_pkg::REG_CLOSE_MS:    prdata = 32'(cfg.close_ms);
      tctc_pkg::REG_TILT_OPEN:   prdata = 32'(cfg.tilt_open_ms);
      tctc_pkg::REG_TILT_CLOSE:  prdata = 32'(cfg.tilt_close_ms);
      tctc_pkg::REG_ILK_WAIT:    prdata = 32'(cfg.ilk_wait_ms);
      tctc_pkg::REG_RECAL_CLOSE: prdata = 32'(cfg.recal_close_ms);
      tctc_pkg::REG_RECAL_OPEN:  prdata = 32'(cfg.recal_open_ms);
      default:                   prdata = 32'(cfg.link_mode);
    endcase
  end

  // The sequencer owns the handshakes; the datapath owns the cover state and result word.
  tctc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  tctc_datapath #(
    .INERTIA_OPEN_MS     (INERTIA_OPEN_MS),
    .INERTIA_CLOSE_MS    (INERTIA_CLOSE_MS),
    .ACTIVATION_OPEN_MS  (ACTIVATION_OPEN_MS),
    .ACTIVATION_CLOSE_MS (ACTIVATION_CLOSE_MS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cfg             (cfg),
    .command         (command),
    .elapsed_ms      (elapsed_ms),
    .has_position    (has_position),
    .target_position (target_position),
    .has_tilt        (has_tilt),
    .target_tilt     (target_tilt),
    .motor_event     (motor_event),
    .operation       (operation),
    .position_report (position_report),
    .tilt_report     (tilt_report),
    .publish         (publish)
  );

  // A word just accepted keeps the input stalled while it is being worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A stop event always leaves the cover with no operation in progress.
  a_stop_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (motor_event == tctc_pkg::EV_STOP)) |-> (operation == tctc_pkg::OP_IDLE))
    else $error("stop event reported with an operation in progress");

  // Estimates never leave the Q16 range.
  a_report_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((position_report <= tctc_pkg::FULL_Q) && (tilt_report <= tctc_pkg::FULL_Q)))
    else $error("position or tilt estimate beyond full scale");

endmodule

`default_nettype wire
